@@ design/sgfp_pkg.sv @@
`default_nettype none

package sgfp_pkg;

    // Largest entry count a frame may declare.
    localparam int SGFP_MAX_ENTRIES = 16;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_TOTAL,
        PH_COUNT,
        PH_ELEN,
        PH_PAYLOAD,
        PH_DEAD,
        PH_TAIL
    } phase_t;

    typedef enum logic [2:0] {
        KIND_MAGIC,
        KIND_TOTAL,
        KIND_COUNT,
        KIND_ELEN,
        KIND_PAYLOAD,
        KIND_DISCARD
    } byte_kind_t;

    typedef struct packed {
        logic [7:0] out_byte;
        byte_kind_t byte_kind;
        logic [3:0] entry_number;
        logic       entry_last;
        logic       frame_last;
        logic       magic_error;
        logic       length_error;
        logic       count_error;
    } result_t;

endpackage

`default_nettype wire

@@ design/sgfp_parse.sv @@
`default_nettype none

module sgfp_parse
    import sgfp_pkg::*;
#(
    parameter int MAX_ENTRIES = SGFP_MAX_ENTRIES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  in_byte,
    input  wire logic [63:0] frame_magic,
    output result_t          result
);

    localparam int EL_W = $clog2(MAX_ENTRIES + 1);

    phase_t          phase_reg, phase_next, phase_pre;
    logic [2:0]      field_byte_pos_reg, field_byte_pos_next;
    logic [63:0]     field_shift_reg, field_shift_next;
    logic [63:0]     frame_bytes_left_reg, frame_bytes_left_next;
    logic [EL_W-1:0] entries_left_reg, entries_left_next;
    logic [3:0]      current_entry_reg, current_entry_next;
    logic [63:0]     entry_bytes_left_reg, entry_bytes_left_next;
    logic            error_latch_reg, error_latch_next;

    logic            field_done;
    logic [63:0]     field_value;
    logic [63:0]     frame_left_dec;
    logic [63:0]     entry_left_dec;
    logic [EL_W-1:0] entries_fin;
    logic            count_over;
    logic            dead;
    logic            frame_end;

    assign dead        = error_latch_reg || (phase_reg == PH_DEAD) || (phase_reg > PH_TAIL);
    assign field_done  = (field_byte_pos_reg == 3'd7);
    assign field_value = field_shift_reg | ({56'd0, in_byte} << {field_byte_pos_reg, 3'b000});
    assign frame_left_dec = (frame_bytes_left_reg != 64'd0) ? frame_bytes_left_reg - 64'd1
                                                            : 64'd0;
    assign entry_left_dec = (entry_bytes_left_reg != 64'd0) ? entry_bytes_left_reg - 64'd1
                                                            : 64'd0;
    assign entries_fin = (entries_left_reg != '0) ? entries_left_reg - EL_W'(1) : '0;
    assign count_over  = (field_value > 64'(MAX_ENTRIES));

    // Next state for one byte.
    always_comb
    begin
        phase_pre             = phase_reg;
        field_byte_pos_next   = field_byte_pos_reg;
        field_shift_next      = field_shift_reg;
        frame_bytes_left_next = frame_bytes_left_reg;
        entries_left_next     = entries_left_reg;
        current_entry_next    = current_entry_reg;
        entry_bytes_left_next = entry_bytes_left_reg;
        error_latch_next      = error_latch_reg;
        frame_end             = 1'b0;

        if (phase_reg == PH_MAGIC || phase_reg == PH_TOTAL || phase_reg == PH_COUNT
            || phase_reg == PH_ELEN)
        begin
            field_byte_pos_next = field_done ? 3'd0 : field_byte_pos_reg + 3'd1;
            field_shift_next    = field_done ? 64'd0 : field_value;
        end

        if (dead)
        begin
            phase_pre        = PH_DEAD;
            error_latch_next = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_MAGIC:
                begin
                    if (field_done)
                    begin
                        if (field_value != frame_magic)
                        begin
                            error_latch_next = 1'b1;
                            phase_pre        = PH_DEAD;
                        end
                        else
                        begin
                            phase_pre = PH_TOTAL;
                        end
                    end
                end
                PH_TOTAL:
                begin
                    if (field_done)
                    begin
                        frame_bytes_left_next = field_value;
                        if (field_value == 64'd0)
                        begin
                            frame_end = 1'b1;
                        end
                        else
                        begin
                            phase_pre = PH_COUNT;
                        end
                    end
                end
                PH_COUNT:
                begin
                    if (field_done)
                    begin
                        entries_left_next  = count_over ? EL_W'(MAX_ENTRIES)
                                                        : field_value[EL_W-1:0];
                        current_entry_next = 4'd0;
                        phase_pre = (count_over || field_value[EL_W-1:0] != '0) ? PH_ELEN
                                                                               : PH_TAIL;
                    end
                end
                PH_ELEN:
                begin
                    if (field_done)
                    begin
                        entry_bytes_left_next = field_value;
                        if (field_value == 64'd0)
                        begin
                            entries_left_next  = entries_fin;
                            current_entry_next = current_entry_reg + 4'd1;
                            phase_pre = (entries_fin != '0) ? PH_ELEN : PH_TAIL;
                        end
                        else
                        begin
                            phase_pre = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    entry_bytes_left_next = entry_left_dec;
                    if (entry_left_dec == 64'd0)
                    begin
                        entries_left_next  = entries_fin;
                        current_entry_next = current_entry_reg + 4'd1;
                        phase_pre = (entries_fin != '0) ? PH_ELEN : PH_TAIL;
                    end
                end
                default:
                begin
                    phase_pre = phase_reg;
                end
            endcase

            // Past the header every byte uses up the total length.
            if (phase_reg == PH_COUNT || phase_reg == PH_ELEN || phase_reg == PH_PAYLOAD
                || phase_reg == PH_TAIL)
            begin
                frame_bytes_left_next = frame_left_dec;
                if (frame_left_dec == 64'd0)
                begin
                    frame_end = 1'b1;
                end
            end
        end

        phase_next = phase_pre;
        if (frame_end)
        begin
            phase_next            = PH_MAGIC;
            field_byte_pos_next   = 3'd0;
            field_shift_next      = 64'd0;
            frame_bytes_left_next = 64'd0;
            entries_left_next     = '0;
            current_entry_next    = 4'd0;
            entry_bytes_left_next = 64'd0;
        end
    end

    // Result for the same byte.
    always_comb
    begin
        result              = '0;
        result.out_byte     = in_byte;
        result.byte_kind    = KIND_DISCARD;
        result.magic_error  = error_latch_next;
        result.frame_last   = frame_end;
        result.length_error = frame_end && (phase_pre != PH_TAIL) && !dead
                              && (phase_reg != PH_TOTAL);
        if (!dead)
        begin
            case (phase_reg)
                PH_MAGIC:
                begin
                    result.byte_kind = KIND_MAGIC;
                end
                PH_TOTAL:
                begin
                    result.byte_kind = KIND_TOTAL;
                end
                PH_COUNT:
                begin
                    result.byte_kind   = KIND_COUNT;
                    result.count_error = field_done && count_over;
                end
                PH_ELEN:
                begin
                    result.byte_kind    = KIND_ELEN;
                    result.entry_number = current_entry_reg;
                    result.entry_last   = field_done && (field_value == 64'd0);
                end
                PH_PAYLOAD:
                begin
                    result.byte_kind    = KIND_PAYLOAD;
                    result.entry_number = current_entry_reg;
                    result.entry_last   = (entry_left_dec == 64'd0);
                end
                default:
                begin
                    result.byte_kind = KIND_DISCARD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_MAGIC;
            field_byte_pos_reg   <= 3'd0;
            field_shift_reg      <= 64'd0;
            frame_bytes_left_reg <= 64'd0;
            entries_left_reg     <= '0;
            current_entry_reg    <= 4'd0;
            entry_bytes_left_reg <= 64'd0;
            error_latch_reg      <= 1'b0;
        end
        else if (step)
        begin
            phase_reg            <= phase_next;
            field_byte_pos_reg   <= field_byte_pos_next;
            field_shift_reg      <= field_shift_next;
            frame_bytes_left_reg <= frame_bytes_left_next;
            entries_left_reg     <= entries_left_next;
            current_entry_reg    <= current_entry_next;
            entry_bytes_left_reg <= entry_bytes_left_next;
            error_latch_reg      <= error_latch_next;
        end
    end

endmodule

`default_nettype wire

@@ design/scatter_gather_frame_parser.sv @@
`default_nettype none

// Frame parser for a length-prefixed byte stream: magic, total length, entry
// count, then an entry length and its payload for every entry, all fields
// 64-bit little-endian.
// The slave stream takes one byte per request in s_axis_tdata. The master
// stream returns one request per byte: the byte itself in m_axis_tdata, its
// classification and flags in m_axis_tuser, and the end of frame on tlast.
// The expected magic is loaded through the cfg channel, which is always ready
// and must only be written while no bytes are in flight.
// A byte passes an input register, the parse step and a result register. One
// byte is taken every cycle while the receiver keeps m_axis_tready high; the
// rate is set by the combinational parse step with its 64-bit length
// down-counters and magic compare.
// When the receiver stalls, the result register holds and the input register
// still takes one more byte; after that s_axis_tready drops until tready
// returns. Reset clears the parse state, the sticky magic error and the
// magic register to zero, and empties both registers.
module scatter_gather_frame_parser
    import sgfp_pkg::*;
#(
    parameter int MAX_ENTRIES = SGFP_MAX_ENTRIES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [63:0] cfg_data,      // frame_magic

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] in_byte

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
    output logic             m_axis_tlast,  // frame_last
    output logic [10:0]      m_axis_tuser   // [2:0] byte_kind, [6:3] entry_number,
                                            // [7] entry_last, [8] magic_error,
                                            // [9] length_error, [10] count_error
);

    logic [63:0] frame_magic_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    logic        advance;

    // The byte in the input register moves on whenever the result slot is
    // free or being emptied in this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_magic_reg <= 64'd0;
        end
        else if (cfg_valid)
        begin
            frame_magic_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    sgfp_parse #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .in_byte     (in_byte_reg),
        .frame_magic (frame_magic_reg),
        .result      (result_next)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result_reg.out_byte;
    assign m_axis_tlast  = result_reg.frame_last;
    assign m_axis_tuser  = {result_reg.count_error, result_reg.length_error,
                            result_reg.magic_error, result_reg.entry_last,
                            result_reg.entry_number, result_reg.byte_kind};

`ifndef SYNTHESIS
    // A short frame is always reported on the byte that closes it.
    a_len_err_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.length_error) |-> result_reg.frame_last)
        else $error("length error without frame end");

    // The magic error stays set on every later result until reset.
    a_magic_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && result_reg.magic_error)
        |=> (!m_axis_tvalid || result_reg.magic_error))
        else $error("magic error dropped");

    // Only entry length and payload bytes can close an entry.
    a_entry_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.entry_last)
        |-> (result_reg.byte_kind == KIND_ELEN || result_reg.byte_kind == KIND_PAYLOAD))
        else $error("entry end on wrong byte kind");

    // With the result slot empty the input side never stalls.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled while output empty");
`endif

endmodule

`default_nettype wire
